/* rtl/smf_pkg.sv */
// Shared types and constants for the separable median filter.
// No dependencies; the median, store and top-level files import this package.
package smf_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } smf_cfg_idx_e;

  localparam logic [2:0]            WINDOW_RST = 3'd3;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 10'd512;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 10'd512;

  localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // Input beat: pixel or drain
  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel_in;
  } smf_in_t;

  // Output beat
  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } smf_out_t;

endpackage

/* rtl/smf_stream_if.sv */
// Valid/ready stream channel carrying one payload beat.
// Payload type is given per instance; used with smf_pkg structs.
interface smf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/smf_median.sv */
// Median of N 8-bit values through an odd-even transposition network.
// Depends on smf_pkg for the pixel width.
module smf_median
  import smf_pkg::*;
#(
  parameter int N = 7
) (
  input  logic [N-1:0][PIX_W-1:0] vals_i,
  output logic [PIX_W-1:0]        med_o
);

  // Compare-exchange rounds, alternating even and odd pairs
  always_comb begin
    logic [N-1:0][PIX_W-1:0] a;
    logic [PIX_W-1:0]        t;
    a = vals_i;
    t = '0;
    for (int r = 0; r < N; r++) begin
      for (int i = r % 2; i + 1 < N; i += 2) begin
        if (a[i] > a[i+1]) begin
          t      = a[i];
          a[i]   = a[i+1];
          a[i+1] = t;
        end
      end
    end
    med_o = a[N/2];
  end

endmodule

/* rtl/smf_line_store.sv */
// Interim line store: one word per column, one byte lane per buffered row.
// Synchronous read, byte-lane write, same-cycle write merged into read data.
module smf_line_store
  import smf_pkg::*;
#(
  parameter int COLS = 512,
  parameter int AW   = 9,
  parameter int LR   = 8,
  parameter int LW   = 3
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic [LW-1:0]            wr_lane_i,
  input  logic [PIX_W-1:0]         wr_data_i,
  output logic [LR-1:0][PIX_W-1:0] rd_data_o
);

  logic [LR-1:0][PIX_W-1:0] mem [COLS];
  logic [LR-1:0][PIX_W-1:0] rdata_q;
  logic                     fwd_q;
  logic [LW-1:0]            fwd_lane_q;
  logic [PIX_W-1:0]         fwd_data_q;

  // Byte-lane write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i][wr_lane_i] <= wr_data_i;
    end
  end

  // Registered read, capture colliding write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      fwd_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      fwd_lane_q <= wr_lane_i;
      fwd_data_q <= wr_data_i;
    end
  end

  always_comb begin
    rd_data_o = rdata_q;
    if (fwd_q) begin
      rd_data_o[fwd_lane_q] = fwd_data_q;
    end
  end

endmodule

/* rtl/smf_raw_delay.sv */
// Circular delay store for raw pixels used on border rows.
// Synchronous read; a read of the slot written in the same cycle sees the new pixel.
module smf_raw_delay
  import smf_pkg::*;
#(
  parameter int DEPTH = 1540,
  parameter int AW    = 11
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [PIX_W-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [PIX_W-1:0] rd_data_o
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;
  logic             fwd_q;
  logic [PIX_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      fwd_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

/* rtl/separable_median_filter_unit.sv */
// Separable median filter top level: counters, row window, pipeline, output register.
// Depends on smf_pkg, smf_stream_if, smf_median, smf_line_store, smf_raw_delay.
//
//  channel  | dir | beat fields               | accepted when
//  ---------+-----+---------------------------+------------------------
//  in_if    | in  | mode, pixel_in            | in_if.valid & in_if.ready
//  out_if   | out | pixel_out, frame_last     | out_if.valid & out_if.ready
//  cfg      | in  | cfg_idx_i, cfg_data_i     | cfg_we_i
//
// One beat per cycle while the output is not stalled; a result passes the stage 1 registers
// with the line store read, the stage 2 registers after the merge and the output register after the column median.
// The whole pipeline advances together: it stalls only while a result sits in
// the output register and out_if.ready is low.
// Reset clears control state only; the stores need no clearing pass.
module separable_median_filter_unit
  import smf_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_WINDOW = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  smf_stream_if.sink            in_if,
  smf_stream_if.source          out_if
);

  localparam int HMAX = MAX_WINDOW / 2;
  localparam int N    = 2 * HMAX + 1;
  localparam int HW   = (HMAX > 0) ? $clog2(HMAX + 1) : 1;
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HTW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 2 * HMAX + 2) + 1;
  localparam int LW   = (N > 1) ? $clog2(N) : 1;
  localparam int LR   = 2 ** LW;
  localparam int RD   = HMAX * (MAX_WIDTH + 1) + 1;
  localparam int RPW  = (RD > 1) ? $clog2(RD) : 1;

  // Configuration registers
  logic [2:0]            win_q;
  logic [CFG_DATA_W-1:0] fwidth_q, fheight_q;
  logic                  cfg_hit;

  // Effective geometry
  logic [2:0]     wsel;
  logic [HW-1:0]  h;
  logic [CW-1:0]  w_eff;
  logic [HTW-1:0] ht_eff;
  logic [RPW-1:0] lag;

  // Position counters
  logic [COLW-1:0] in_col_q, in_col_d;
  logic [RW-1:0]   in_row_q, in_row_d;
  logic [COLW-1:0] ccol_q, ccol_d;
  logic [RW-1:0]   crow_q, crow_d;
  logic [HW-1:0]   pre_q, pre_d;
  logic [RPW-1:0]  raw_ptr_q, raw_ptr_d;
  logic [RPW-1:0]  raw_rd;

  // Row window, newest pixel in entry 0
  logic [N-1:0][PIX_W-1:0] win_px_q;

  // Stage 0 decode
  logic             en, acc, full, adv, started, wr0, out0, last0, colbig0, border0;
  logic [PIX_W-1:0] p;

  // Stage 1
  logic                    s1_wr_q, s1_out_q, s1_last_q, s1_colbig_q, s1_border_q;
  logic [HW-1:0]           s1_h_q;
  logic [LW-1:0]           s1_lane_q;
  logic [COLW-1:0]         s1_col_q;
  logic [N-1:0][PIX_W-1:0] vals1;
  logic [PIX_W-1:0]        med1, centre, wval, raw1;
  logic [LR-1:0][PIX_W-1:0] rword, word1;

  // Stage 2
  logic                     s2_out_q, s2_last_q, s2_border_q;
  logic [HW-1:0]            s2_h_q;
  logic [LW-1:0]            s2_lane_q;
  logic [LR-1:0][PIX_W-1:0] s2_word_q;
  logic [PIX_W-1:0]         s2_raw_q;
  logic [N-1:0][PIX_W-1:0]  vals2;
  logic [PIX_W-1:0]         med2;

  // Output register
  logic     out_valid_q;
  smf_out_t out_data_q;

  // Configuration write decode
  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_idx_i)
      CFG_WINDOW, CFG_WIDTH, CFG_HEIGHT: cfg_hit = cfg_we_i;
      default:                           cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= WINDOW_RST;
      fwidth_q  <= WIDTH_RST;
      fheight_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW: win_q     <= cfg_data_i[2:0];
        CFG_WIDTH:  fwidth_q  <= cfg_data_i;
        CFG_HEIGHT: fheight_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Half window and clamped frame size
  always_comb begin
    wsel = win_q;
    if (wsel == 3'd0) wsel = 3'd1;
    if (!wsel[0]) wsel = wsel - 3'd1;
    if (32'(wsel >> 1) > HMAX) h = HW'(HMAX);
    else h = HW'(wsel >> 1);

    if (fwidth_q == '0) w_eff = CW'(1);
    else if (32'(fwidth_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(fwidth_q);

    if (fheight_q == '0) ht_eff = HTW'(1);
    else if (32'(fheight_q) > MAX_HEIGHT) ht_eff = HTW'(MAX_HEIGHT);
    else ht_eff = HTW'(fheight_q);

    lag = RPW'(32'(h) * 32'(w_eff) + 32'(h));
  end

  // Stage 0: advance decision and per-beat flags
  assign en        = !out_valid_q || out_if.ready;
  assign in_if.ready = en;
  assign acc     = in_if.valid && en;
  assign full    = 32'(in_row_q) >= 32'(ht_eff);
  assign adv     = acc && (in_if.data.mode ? full : !full);
  assign p       = full ? PIX_MIN : in_if.data.pixel_in;
  assign started = (pre_q == h);
  assign wr0     = adv && started;
  assign out0    = wr0 && (32'(crow_q) >= 32'(h));
  assign last0   = out0 && (32'(crow_q) == 32'(ht_eff) + 32'(h) - 1)
                   && (32'(ccol_q) == 32'(w_eff) - 1);
  assign colbig0 = 32'(in_col_q) >= 2 * 32'(h);
  assign border0 = (32'(crow_q) < 2 * 32'(h)) || (32'(crow_q) >= 32'(ht_eff));

  // Raw delay read slot
  always_comb begin
    if (32'(raw_ptr_q) >= 32'(lag)) raw_rd = raw_ptr_q - lag;
    else raw_rd = RPW'(32'(raw_ptr_q) + RD - 32'(lag));
  end

  // Counter next state
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    ccol_d    = ccol_q;
    crow_d    = crow_q;
    pre_d     = pre_q;
    raw_ptr_d = raw_ptr_q;
    if (adv) begin
      if (32'(raw_ptr_q) + 1 >= RD) raw_ptr_d = '0;
      else raw_ptr_d = raw_ptr_q + RPW'(1);
      if (32'(in_col_q) + 1 >= 32'(w_eff)) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + COLW'(1);
      end
      if (!started) begin
        pre_d = pre_q + HW'(1);
      end else if (32'(ccol_q) + 1 >= 32'(w_eff)) begin
        ccol_d = '0;
        crow_d = crow_q + RW'(1);
      end else begin
        ccol_d = ccol_q + COLW'(1);
      end
    end
    // Frame restart after the final output or a register write
    if ((adv && last0) || cfg_hit) begin
      in_col_d = '0;
      in_row_d = '0;
      ccol_d   = '0;
      crow_d   = '0;
      pre_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      ccol_q    <= '0;
      crow_q    <= '0;
      pre_q     <= '0;
      raw_ptr_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      ccol_q    <= ccol_d;
      crow_q    <= crow_d;
      pre_q     <= pre_d;
      raw_ptr_q <= raw_ptr_d;
    end
  end

  // Row window shift
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = N - 1; i > 0; i--) begin
        win_px_q[i] <= win_px_q[i-1];
      end
      win_px_q[0] <= p;
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_wr_q  <= 1'b0;
      s1_out_q <= 1'b0;
    end else if (en) begin
      s1_wr_q  <= wr0;
      s1_out_q <= out0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_last_q   <= last0;
      s1_colbig_q <= colbig0;
      s1_border_q <= border0;
      s1_h_q      <= h;
      s1_lane_q   <= crow_q[LW-1:0];
      s1_col_q    <= ccol_q;
    end
  end

  // Stage 1: horizontal median, padded evenly with min and max
  always_comb begin
    centre = win_px_q[0];
    for (int i = 0; i < N; i++) begin
      if (i <= 2 * int'(s1_h_q)) vals1[i] = win_px_q[i];
      else vals1[i] = (i % 2 == 1) ? PIX_MIN : PIX_MAX;
      if (i == int'(s1_h_q)) centre = win_px_q[i];
    end
  end

  smf_median #(.N(N)) u_row_med (
    .vals_i (vals1),
    .med_o  (med1)
  );

  assign wval = s1_colbig_q ? med1 : centre;

  smf_line_store #(
    .COLS (MAX_WIDTH),
    .AW   (COLW),
    .LR   (LR),
    .LW   (LW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (en),
    .rd_addr_i (ccol_q),
    .wr_en_i   (en && s1_wr_q),
    .wr_addr_i (s1_col_q),
    .wr_lane_i (s1_lane_q),
    .wr_data_i (wval),
    .rd_data_o (rword)
  );

  smf_raw_delay #(
    .DEPTH (RD),
    .AW    (RPW)
  ) u_raw_delay (
    .clk_i     (clk_i),
    .wr_en_i   (adv),
    .wr_addr_i (raw_ptr_q),
    .wr_data_i (p),
    .rd_en_i   (en),
    .rd_addr_i (raw_rd),
    .rd_data_o (raw1)
  );

  // Bottom row of the column window is this beat's own write
  always_comb begin
    word1            = rword;
    word1[s1_lane_q] = wval;
  end

  // Stage 2 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_out_q <= 1'b0;
    end else if (en) begin
      s2_out_q <= s1_out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_last_q   <= s1_last_q;
      s2_border_q <= s1_border_q;
      s2_h_q      <= s1_h_q;
      s2_lane_q   <= s1_lane_q;
      s2_word_q   <= word1;
      s2_raw_q    <= raw1;
    end
  end

  // Stage 2: gather the column rows and take their median
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i <= 2 * int'(s2_h_q)) begin
        vals2[i] = s2_word_q[LW'(s2_lane_q + LW'(i) - LW'({s2_h_q, 1'b0}))];
      end else begin
        vals2[i] = (i % 2 == 1) ? PIX_MIN : PIX_MAX;
      end
    end
  end

  smf_median #(.N(N)) u_col_med (
    .vals_i (vals2),
    .med_o  (med2)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s2_out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.pixel_out  <= s2_border_q ? s2_raw_q : med2;
      out_data_q.frame_last <= s2_last_q;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  // Checks
  a_pre_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pre_q <= h) else $error("warm-up count past half window");

  a_in_col_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(in_col_q) < 32'(w_eff)) else $error("input column past row end");

  a_ccol_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ccol_q) < 32'(w_eff)) else $error("centre column past row end");

  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last0) |=> (in_row_q == '0 && crow_q == '0 && pre_q == '0))
    else $error("counters not cleared after final output");

endmodule
